// File: hw/rtl/triangle_unit_normal_core_assert.svh
// Assertion macros used by the triangle normal top level
`ifndef TRIANGLE_UNIT_NORMAL_CORE_ASSERT_SVH
`define TRIANGLE_UNIT_NORMAL_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication, sampled on clk, off during reset
`define TUN_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("triangle normal assertion failed");
// next-cycle implication
`define TUN_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("triangle normal assertion failed");
`else
`define TUN_ASSERT_IMP(label, ante, cons)
`define TUN_ASSERT_NXT(label, ante, cons)
`endif
`endif

// File: hw/rtl/tun_pkg.sv
// Shared types and constants of the triangle normal pipeline
`default_nettype none
package tun_pkg;
	localparam int unsigned AXES = 3;

	// control that travels with every request down the pipeline
	typedef struct packed {
		logic            vld;
		logic            dgn;
		logic [AXES-1:0] neg;
	} tun_ctl_t;
endpackage
`default_nettype wire

// File: hw/rtl/tun_cross.sv
// Edge vectors and cross product, sign and magnitude out
`default_nettype none
module tun_cross #(
	parameter int unsigned CW = 16,
	parameter int unsigned MW = 2*CW+1
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_vld,
	input  logic signed [CW-1:0]               a_x,
	input  logic signed [CW-1:0]               a_y,
	input  logic signed [CW-1:0]               a_z,
	input  logic signed [CW-1:0]               b_x,
	input  logic signed [CW-1:0]               b_y,
	input  logic signed [CW-1:0]               b_z,
	input  logic signed [CW-1:0]               c_x,
	input  logic signed [CW-1:0]               c_y,
	input  logic signed [CW-1:0]               c_z,
	output tun_pkg::tun_ctl_t                  ctl,
	output logic [tun_pkg::AXES-1:0][MW-1:0]   mag
);
	import tun_pkg::*;

	localparam int unsigned EW = CW+1;
	localparam int unsigned PW = 2*EW;
	localparam int unsigned DW = PW+1;

	logic                   vld_s1, vld_s2, vld_s3;
	logic signed [EW-1:0]   e1_s1 [AXES];
	logic signed [EW-1:0]   e2_s1 [AXES];
	logic signed [PW-1:0]   p_s2 [AXES];
	logic signed [PW-1:0]   q_s2 [AXES];
	logic signed [DW-1:0]   diff [AXES];
	logic [AXES-1:0][MW-1:0] mag_s3;
	logic [AXES-1:0]        neg_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// edges e1 = b - a, e2 = c - a
	always_ff @(posedge clk) begin
		e1_s1[0] <= EW'(b_x) - EW'(a_x);
		e1_s1[1] <= EW'(b_y) - EW'(a_y);
		e1_s1[2] <= EW'(b_z) - EW'(a_z);
		e2_s1[0] <= EW'(c_x) - EW'(a_x);
		e2_s1[1] <= EW'(c_y) - EW'(a_y);
		e2_s1[2] <= EW'(c_z) - EW'(a_z);
	end

	for (genvar k = 0; k < AXES; k++) begin : g_axis
		always_ff @(posedge clk) begin
			p_s2[k] <= PW'(e1_s1[(k+1)%AXES]) * PW'(e2_s1[(k+2)%AXES]);
			q_s2[k] <= PW'(e1_s1[(k+2)%AXES]) * PW'(e2_s1[(k+1)%AXES]);
		end

		assign diff[k] = DW'(p_s2[k]) - DW'(q_s2[k]);

		always_ff @(posedge clk) begin
			neg_s3[k] <= diff[k][DW-1];
			mag_s3[k] <= diff[k][DW-1] ? MW'(-diff[k]) : MW'(diff[k]);
		end
	end

	assign ctl.vld = vld_s3;
	assign ctl.dgn = 1'b0;
	assign ctl.neg = neg_s3;
	assign mag     = mag_s3;
endmodule
`default_nettype wire

// File: hw/rtl/tun_sumsq.sv
// Squared length of the cross product, squares split in half-width products
`default_nettype none
module tun_sumsq #(
	parameter int unsigned MW = 33,
	parameter int unsigned SW = 2*MW+2
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  tun_pkg::tun_ctl_t                ctl_in,
	input  logic [tun_pkg::AXES-1:0][MW-1:0] mag_in,
	output tun_pkg::tun_ctl_t                ctl,
	output logic [tun_pkg::AXES-1:0][MW-1:0] mag,
	output logic [SW-1:0]                    sum
);
	import tun_pkg::*;

	localparam int unsigned H  = (MW+1)/2;
	localparam int unsigned HH = MW-H;
	localparam int unsigned QW = 2*MW;

	tun_ctl_t                ctl_s1, ctl_s2, ctl_s3;
	logic [AXES-1:0][MW-1:0] mag_s1, mag_s2, mag_s3;
	logic [MW+H-1:0]         pl_s1 [AXES];
	logic [MW+HH-1:0]        ph_s1 [AXES];
	logic [QW-1:0]           sq_s2 [AXES];
	logic                    zero_s2;
	logic [SW-1:0]           sum_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else begin
			ctl_s1 <= ctl_in;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= '{vld: ctl_s2.vld, dgn: zero_s2, neg: ctl_s2.neg};
		end
	end

	for (genvar k = 0; k < AXES; k++) begin : g_axis
		always_ff @(posedge clk) begin
			pl_s1[k] <= (MW+H)'(mag_in[k]) * (MW+H)'(mag_in[k][H-1:0]);
			ph_s1[k] <= (MW+HH)'(mag_in[k]) * (MW+HH)'(mag_in[k][MW-1:H]);
			sq_s2[k] <= QW'(pl_s1[k]) + (QW'(ph_s1[k]) << H);
		end
	end

	always_ff @(posedge clk) begin
		mag_s1  <= mag_in;
		mag_s2  <= mag_s1;
		mag_s3  <= mag_s2;
		zero_s2 <= (mag_s1 == '0);
		sum_s3  <= SW'(sq_s2[0]) + SW'(sq_s2[1]) + SW'(sq_s2[2]);
	end

	assign ctl = ctl_s3;
	assign mag = mag_s3;
	assign sum = sum_s3;
endmodule
`default_nettype wire

// File: hw/rtl/tun_isqrt.sv
// Pipelined integer square root, one root bit per stage
`default_nettype none
module tun_isqrt #(
	parameter int unsigned RW = 96,
	parameter int unsigned MW = 33,
	parameter int unsigned LW = RW/2
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  tun_pkg::tun_ctl_t                ctl_in,
	input  logic [tun_pkg::AXES-1:0][MW-1:0] mag_in,
	input  logic [RW-1:0]                    rad_in,
	output tun_pkg::tun_ctl_t                ctl,
	output logic [tun_pkg::AXES-1:0][MW-1:0] mag,
	output logic [LW-1:0]                    root
);
	import tun_pkg::*;

	localparam int unsigned RMW = LW+3;

	typedef logic [AXES-1:0][MW-1:0] mag_t;

	tun_ctl_t         ctl_s  [LW];
	mag_t             mag_s  [LW];
	logic [RMW-1:0]   rem_s  [LW];
	logic [LW-1:0]    root_s [LW];
	logic [RW-1:0]    rad_s  [LW];

	for (genvar g = 0; g < LW; g++) begin : g_stg
		logic [RMW-1:0] rem_i;
		logic [RMW-1:0] acc;
		logic [RMW-1:0] trial;
		logic [LW-1:0]  root_i;
		logic [RW-1:0]  rad_i;
		mag_t           mag_i;
		tun_ctl_t       ctl_i;
		logic           take;

		if (g == 0) begin : g_first
			assign rem_i  = '0;
			assign root_i = '0;
			assign rad_i  = rad_in;
			assign mag_i  = mag_in;
			assign ctl_i  = ctl_in;
		end else begin : g_next
			assign rem_i  = rem_s[g-1];
			assign root_i = root_s[g-1];
			assign rad_i  = rad_s[g-1];
			assign mag_i  = mag_s[g-1];
			assign ctl_i  = ctl_s[g-1];
		end

		// bring down two radicand bits, try root*4+1
		assign acc   = {rem_i[RMW-3:0], rad_i[RW-1 -: 2]};
		assign trial = RMW'({root_i, 2'b01});
		assign take  = (acc >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[g] <= '0;
			end else begin
				ctl_s[g] <= ctl_i;
			end
		end

		always_ff @(posedge clk) begin
			rem_s[g]  <= take ? (acc - trial) : acc;
			root_s[g] <= {root_i[LW-2:0], take};
			rad_s[g]  <= rad_i << 2;
			mag_s[g]  <= mag_i;
		end
	end

	assign ctl  = ctl_s[LW-1];
	assign mag  = mag_s[LW-1];
	assign root = root_s[LW-1];
endmodule
`default_nettype wire

// File: hw/rtl/tun_div.sv
// Three restoring divider lanes, one quotient bit per stage
`default_nettype none
module tun_div #(
	parameter int unsigned LW = 48,
	parameter int unsigned MW = 33,
	parameter int unsigned F  = 14
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  tun_pkg::tun_ctl_t               ctl_in,
	input  logic [tun_pkg::AXES-1:0][MW-1:0] mag_in,
	input  logic [LW-1:0]                   den_in,
	output tun_pkg::tun_ctl_t               ctl,
	output logic [tun_pkg::AXES-1:0][F:0]   quo
);
	import tun_pkg::*;

	localparam int unsigned RW = LW+1;
	localparam int unsigned NS = F+1;

	typedef logic [AXES-1:0][RW-1:0] rem_t;
	typedef logic [AXES-1:0][F:0]    quo_t;

	tun_ctl_t       ctl_s [NS];
	rem_t           rem_s [NS];
	quo_t           quo_s [NS];
	logic [LW-1:0]  den_s [NS];

	for (genvar g = 0; g < NS; g++) begin : g_stg
		rem_t          rem_i;
		quo_t          quo_i;
		logic [LW-1:0] den_i;
		tun_ctl_t      ctl_i;
		rem_t          rem_o;
		quo_t          quo_o;

		if (g == 0) begin : g_first
			// numerator is mag * 4^F; its top part mag * 2^(F-1) is below the divisor
			for (genvar k = 0; k < AXES; k++) begin : g_ld
				assign rem_i[k] = RW'(mag_in[k]) << (F-1);
			end
			assign quo_i = '0;
			assign den_i = den_in;
			assign ctl_i = ctl_in;
		end else begin : g_next
			assign rem_i = rem_s[g-1];
			assign quo_i = quo_s[g-1];
			assign den_i = den_s[g-1];
			assign ctl_i = ctl_s[g-1];
		end

		always_comb begin
			logic [RW-1:0] sh;
			for (int k = 0; k < AXES; k++) begin
				sh = {rem_i[k][LW-1:0], 1'b0};
				if (sh >= RW'(den_i)) begin
					rem_o[k] = sh - RW'(den_i);
					quo_o[k] = {quo_i[k][F-1:0], 1'b1};
				end else begin
					rem_o[k] = sh;
					quo_o[k] = {quo_i[k][F-1:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[g] <= '0;
			end else begin
				ctl_s[g] <= ctl_i;
			end
		end

		always_ff @(posedge clk) begin
			rem_s[g] <= rem_o;
			quo_s[g] <= quo_o;
			den_s[g] <= den_i;
		end
	end

	assign ctl = ctl_s[NS-1];
	assign quo = quo_s[NS-1];
endmodule
`default_nettype wire

// File: hw/rtl/triangle_unit_normal_core.sv
// Top level: unit face normal of a triangle, fully pipelined
//
//  channel   direction  handshake        payload
//  request   in         start / busy     a_x a_y a_z b_x b_y b_z c_x c_y c_z
//  result    out        done (strobe)    unit_x unit_y unit_z degenerate
//
// One request is taken every cycle; busy stays low because nothing stalls.
// The root width is LW = 2*COORD_BITS + 2 + OUT_FRAC_BITS.
// The square root, one root bit per stage, is the longest part of the pipeline.
// done is high for exactly one cycle per request, results leave in request order.
// Reset clears only the valid bits and stage control words; payload registers are not reset.
`default_nettype none
`include "triangle_unit_normal_core_assert.svh"
module triangle_unit_normal_core #(
	parameter int unsigned COORD_BITS    = 16,
	parameter int unsigned OUT_FRAC_BITS = 14
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [COORD_BITS-1:0]  a_x,
	input  logic signed [COORD_BITS-1:0]  a_y,
	input  logic signed [COORD_BITS-1:0]  a_z,
	input  logic signed [COORD_BITS-1:0]  b_x,
	input  logic signed [COORD_BITS-1:0]  b_y,
	input  logic signed [COORD_BITS-1:0]  b_z,
	input  logic signed [COORD_BITS-1:0]  c_x,
	input  logic signed [COORD_BITS-1:0]  c_y,
	input  logic signed [COORD_BITS-1:0]  c_z,
	output logic                          done,
	output logic signed [OUT_FRAC_BITS+1:0] unit_x,
	output logic signed [OUT_FRAC_BITS+1:0] unit_y,
	output logic signed [OUT_FRAC_BITS+1:0] unit_z,
	output logic                          degenerate
);
	import tun_pkg::*;

	localparam int unsigned F   = OUT_FRAC_BITS;
	localparam int unsigned OW  = F+2;
	// cross component magnitude, squared length, scaled radicand, root
	localparam int unsigned MW  = 2*COORD_BITS+1;
	localparam int unsigned SW  = 2*MW+2;
	localparam int unsigned RW  = SW+2*F;
	localparam int unsigned LW  = RW/2;
	localparam int unsigned LAT = 3 + 3 + LW + (F+1) + 1;
	localparam int          ONE = 1 << F;

	tun_ctl_t                cr_ctl, sq_ctl, rt_ctl, dv_ctl;
	logic [AXES-1:0][MW-1:0] cr_mag, sq_mag, rt_mag;
	logic [SW-1:0]           sq_sum;
	logic [LW-1:0]           rt_len;
	logic [AXES-1:0][F:0]    dv_quo;
	logic                    done_q;
	logic signed [OW-1:0]    unit_q [AXES];
	logic                    dgn_q;
	logic                    unit_in_range;

	// every request is taken: the pipeline never holds
	assign busy = 1'b0;

	tun_cross #(.CW(COORD_BITS), .MW(MW)) u_cross (
		.clk    (clk),
		.arst_n (arst_n),
		.in_vld (start),
		.a_x    (a_x), .a_y (a_y), .a_z (a_z),
		.b_x    (b_x), .b_y (b_y), .b_z (b_z),
		.c_x    (c_x), .c_y (c_y), .c_z (c_z),
		.ctl    (cr_ctl),
		.mag    (cr_mag)
	);

	tun_sumsq #(.MW(MW), .SW(SW)) u_sumsq (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl_in (cr_ctl),
		.mag_in (cr_mag),
		.ctl    (sq_ctl),
		.mag    (sq_mag),
		.sum    (sq_sum)
	);

	// length in units of 2^-F: root of sum * 4^F
	tun_isqrt #(.RW(RW), .MW(MW), .LW(LW)) u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl_in (sq_ctl),
		.mag_in (sq_mag),
		.rad_in ({sq_sum, {(2*F){1'b0}}}),
		.ctl    (rt_ctl),
		.mag    (rt_mag),
		.root   (rt_len)
	);

	tun_div #(.LW(LW), .MW(MW), .F(F)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl_in (rt_ctl),
		.mag_in (rt_mag),
		.den_in (rt_len),
		.ctl    (dv_ctl),
		.quo    (dv_quo)
	);

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= dv_ctl.vld;
		end
	end

	// apply the sign; drop the quotient of a zero-length normal
	always_ff @(posedge clk) begin
		dgn_q <= dv_ctl.dgn;
		for (int k = 0; k < AXES; k++) begin
			if (dv_ctl.dgn) begin
				unit_q[k] <= '0;
			end else if (dv_ctl.neg[k]) begin
				unit_q[k] <= -OW'(dv_quo[k]);
			end else begin
				unit_q[k] <= OW'(dv_quo[k]);
			end
		end
	end

	assign done       = done_q;
	assign unit_x     = unit_q[0];
	assign unit_y     = unit_q[1];
	assign unit_z     = unit_q[2];
	assign degenerate = dgn_q;

	assign unit_in_range = unit_x <= ONE && unit_x >= -ONE
		&& unit_y <= ONE && unit_y >= -ONE
		&& unit_z <= ONE && unit_z >= -ONE;

	// a result only ever leaves a fixed latency after its request
	`TUN_ASSERT_IMP(a_lat, done, $past(start, LAT))
	// zero-length normal gives all-zero components
	`TUN_ASSERT_IMP(a_dgn_zero, done && degenerate, unit_x == 0 && unit_y == 0 && unit_z == 0)
	// a real normal has some nonzero component
	`TUN_ASSERT_IMP(a_nonzero, done && !degenerate, unit_x != 0 || unit_y != 0 || unit_z != 0)
	// components stay within the unit range
	`TUN_ASSERT_IMP(a_range, done, unit_in_range)
endmodule
`default_nettype wire

// File: tb/sv/testbench.sv
// Testbench for the triangle unit-normal pipeline: a scoreboard predicts and checks each request
`timescale 1ns / 100ps
`default_nettype none

typedef struct {
	logic signed [15:0] ux;
	logic signed [15:0] uy;
	logic signed [15:0] uz;
	logic               dg;
} normal_t;

class normal_scoreboard;
	normal_t pending[$];
	int      errors;

	// exact unit normal, truncated toward zero, in Q1.14
	function automatic normal_t unit_normal(logic signed [15:0] v[9]);
		longint           e1[3], e2[3], n[3];
		logic [127:0]     sumsq, len, cand, num, quo;
		logic signed [15:0] comp[3];
		normal_t          r;
		for (int i = 0; i < 3; i++) begin
			e1[i] = longint'(v[3 + i]) - longint'(v[i]);
			e2[i] = longint'(v[6 + i]) - longint'(v[i]);
		end
		n[0] = e1[1] * e2[2] - e1[2] * e2[1];
		n[1] = e1[2] * e2[0] - e1[0] * e2[2];
		n[2] = e1[0] * e2[1] - e1[1] * e2[0];
		sumsq = 0;
		for (int i = 0; i < 3; i++)
			sumsq += 128'(n[i] < 0 ? -n[i] : n[i]) * 128'(n[i] < 0 ? -n[i] : n[i]);
		if (sumsq == 0) begin
			r.ux = 0; r.uy = 0; r.uz = 0; r.dg = 1'b1;
			return r;
		end
		sumsq = sumsq << 28;
		len = 0;
		for (int b = 63; b >= 0; b--) begin
			cand = len | (128'd1 << b);
			if (cand * cand <= sumsq)
				len = cand;
		end
		for (int i = 0; i < 3; i++) begin
			num = 128'(n[i] < 0 ? -n[i] : n[i]) << 28;
			quo = num / len;
			comp[i] = n[i] < 0 ? -quo[15:0] : quo[15:0];
		end
		r.ux = comp[0]; r.uy = comp[1]; r.uz = comp[2]; r.dg = 1'b0;
		return r;
	endfunction

	function void note_request(logic signed [15:0] v[9]);
		pending.push_back(unit_normal(v));
	endfunction

	function void check_result(logic signed [15:0] ux, logic signed [15:0] uy,
		logic signed [15:0] uz, logic dg);
		normal_t e;
		if (pending.size() == 0) begin
			$display("%0t: unexpected result %0d %0d %0d dg=%0b", $time, ux, uy, uz, dg);
			errors++;
			return;
		end
		e = pending.pop_front();
		if (ux !== e.ux || uy !== e.uy || uz !== e.uz || dg !== e.dg) begin
			$display("%0t: mismatch expected %0d %0d %0d dg=%0b actual %0d %0d %0d dg=%0b",
				$time, e.ux, e.uy, e.uz, e.dg, ux, uy, uz, dg);
			errors++;
		end
	endfunction
endclass

module testbench;
	localparam int RUN_LIMIT = 300000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy, done, degenerate;
	logic signed [15:0] a_x = 0, a_y = 0, a_z = 0, b_x = 0, b_y = 0, b_z = 0;
	logic signed [15:0] c_x = 0, c_y = 0, c_z = 0;
	logic signed [15:0] unit_x, unit_y, unit_z;

	normal_scoreboard sb = new();
	int cycles = 0;

	triangle_unit_normal_core dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.a_x(a_x), .a_y(a_y), .a_z(a_z), .b_x(b_x), .b_y(b_y), .b_z(b_z),
		.c_x(c_x), .c_y(c_y), .c_z(c_z),
		.done(done), .unit_x(unit_x), .unit_y(unit_y), .unit_z(unit_z),
		.degenerate(degenerate)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// note accepted requests and check strobed results on the same edge
	always @(posedge clk) begin
		logic signed [15:0] v[9];
		cycles <= cycles + 1;
		if (arst_n && start && !busy) begin
			v = '{a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z};
			sb.note_request(v);
		end
		if (arst_n && done)
			sb.check_result(unit_x, unit_y, unit_z, degenerate);
		if (cycles >= RUN_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	int burst_left = 0;

	// drive one request, hold it until taken; often pause between bursts
	task automatic send_request(logic signed [15:0] v[9]);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 30);
			if ($urandom_range(0, 3) != 0) begin
				start <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
		burst_left--;
		start <= 1'b1;
		{a_x, a_y, a_z} <= {v[0], v[1], v[2]};
		{b_x, b_y, b_z} <= {v[3], v[4], v[5]};
		{c_x, c_y, c_z} <= {v[6], v[7], v[8]};
		do @(posedge clk); while (busy);
	endtask

	function automatic logic signed [15:0] rnd16();
		return 16'($urandom());
	endfunction

	// triangle shapes: full range, small near a base, collinear, repeated vertex, extreme coordinates
	task automatic send_random();
		logic signed [15:0] v[9];
		logic signed [15:0] base;
		int k;
		case ($urandom_range(0, 5))
			0, 1: for (int i = 0; i < 9; i++) v[i] = rnd16();
			2: for (int i = 0; i < 3; i++) begin
				base = rnd16();
				v[i] = base;
				v[3 + i] = base + 16'($signed($urandom_range(0, 64)) - 32);
				v[6 + i] = base + 16'($signed($urandom_range(0, 64)) - 32);
			end
			3: begin
				k = $signed($urandom_range(0, 6)) - 3;
				for (int i = 0; i < 3; i++) begin
					v[i] = 16'($signed($urandom_range(0, 8000)) - 4000);
					v[3 + i] = v[i] + 16'($signed($urandom_range(0, 4000)) - 2000);
					v[6 + i] = v[i] + 16'(k * (v[3 + i] - v[i]));
				end
			end
			4: begin
				for (int i = 0; i < 9; i++) v[i] = rnd16();
				for (int i = 0; i < 3; i++) v[6 + i] = v[i];
			end
			default: for (int i = 0; i < 9; i++)
				v[i] = $urandom_range(0, 1) ? 16'sh7fff - 16'($urandom_range(0, 3))
					: 16'sh8000 + 16'($urandom_range(0, 3));
		endcase
		send_request(v);
	endtask

	initial begin
		logic signed [15:0] v[9];
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zeros, coincident points, axis-aligned faces, extremes
		v = '{0, 0, 0, 0, 0, 0, 0, 0, 0};                   send_request(v);
		v = '{100, 200, 300, 100, 200, 300, 5, 6, 7};       send_request(v);
		v = '{0, 0, 0, 256, 0, 0, 0, 256, 0};               send_request(v);
		v = '{0, 0, 0, 0, 256, 0, 256, 0, 0};               send_request(v);
		v = '{0, 0, 0, 0, 256, 0, 0, 0, 256};               send_request(v);
		v = '{0, 0, 0, 0, 0, 256, 256, 0, 0};               send_request(v);
		v = '{0, 0, 0, 1, 0, 0, 0, 1, 0};                   send_request(v);
		v = '{0, 0, 0, 1, 1, 1, 2, 2, 2};                   send_request(v);
		v = '{-32768, -32768, -32768, 32767, -32768, -32768,
			-32768, 32767, -32768};                         send_request(v);
		v = '{32767, 32767, 32767, -32768, 32767, 32767,
			32767, -32768, 32767};                          send_request(v);
		v = '{-32768, 32767, -32768, 32767, -32768, 32767,
			-32768, -32768, 32767};                         send_request(v);
		v = '{32767, -32768, 0, -32768, 32767, 0, 0, 0, -32768}; send_request(v);
		v = '{-1, -1, -1, -1, -1, -1, -1, -1, -1};          send_request(v);
		v = '{0, 0, 0, 32767, 1, 0, -32768, 0, 1};          send_request(v);
		v = '{0, 0, 0, 3, 4, 0, -4, 3, 0};                  send_request(v);

		for (int n = 0; n < 1950; n++)
			send_random();
		start <= 1'b0;

		for (int w = 0; w < 5000 && sb.pending.size() != 0; w++)
			@(posedge clk);
		repeat (80) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end
endmodule

`default_nettype wire
